### src/wtfe_pkg.sv
// Package with the shared types, codes, constants and code tables of the frame encoder.
`default_nettype none

package wtfe_pkg;

    // Item actions.
    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_HEADER  = 2'd1,
        ACT_PAYLOAD = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // Coding modes; the unused code behaves as mode C.
    typedef enum logic [1:0] {
        MODE_S    = 2'd0,
        MODE_T    = 2'd1,
        MODE_C    = 2'd2,
        MODE_RSVD = 2'd3
    } mode_t;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_CODING_MODE    = 2'd0,
        REG_FRAME_FORMAT_B = 2'd1,
        REG_PREAMBLE_EXTRA = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

    localparam int RES_MAX = 3;
    localparam int PADDR_W = 4;

    localparam logic [7:0]  PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0]  POSTAMBLE_FULL = 8'h55;
    localparam logic [3:0]  POSTAMBLE_TAIL = 4'h5;
    localparam logic [8:0]  PREAMBLE_MIN = 9'd12;
    localparam logic [31:0] SYNC_S = 32'h5554_7696;
    localparam logic [31:0] SYNC_T = 32'h5555_543D;
    localparam logic [31:0] SYNC_C_A = 32'h543D_54CD;
    localparam logic [31:0] SYNC_C_B = 32'h543D_543D;
    localparam mode_t       CODING_MODE_RESET = MODE_C;

    // Input item.
    typedef struct packed {
        action_t    action;
        logic [7:0] payload_byte;
        logic       last_byte;
    } in_item_t;

    // Result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       header_last;
        logic       frame_last;
    } out_item_t;

    // Configuration registers.
    typedef struct packed {
        mode_t      coding_mode;
        logic       frame_format_b;
        logic [7:0] preamble_extra;
    } cfg_t;

    // Frame state carried from item to item.
    typedef struct packed {
        logic [8:0] header_index;
        logic       header_done;
        logic [3:0] residual_nibble;
        logic       residual_valid;
        logic       frame_active;
    } enc_state_t;

    // Manchester code of one nibble.
    function automatic logic [7:0] manch_byte(input logic [3:0] nib);
        logic [7:0] code;
        case (nib)
            4'h0: code = 8'hAA;
            4'h1: code = 8'hA9;
            4'h2: code = 8'hA6;
            4'h3: code = 8'hA5;
            4'h4: code = 8'h9A;
            4'h5: code = 8'h99;
            4'h6: code = 8'h96;
            4'h7: code = 8'h95;
            4'h8: code = 8'h6A;
            4'h9: code = 8'h69;
            4'hA: code = 8'h66;
            4'hB: code = 8'h65;
            4'hC: code = 8'h5A;
            4'hD: code = 8'h59;
            4'hE: code = 8'h56;
            default: code = 8'h55;
        endcase
        return code;
    endfunction

    // Three-of-six codeword of one nibble.
    function automatic logic [5:0] six_code(input logic [3:0] nib);
        logic [5:0] code;
        case (nib)
            4'h0: code = 6'h16;
            4'h1: code = 6'h0D;
            4'h2: code = 6'h0E;
            4'h3: code = 6'h0B;
            4'h4: code = 6'h1C;
            4'h5: code = 6'h19;
            4'h6: code = 6'h1A;
            4'h7: code = 6'h13;
            4'h8: code = 6'h2C;
            4'h9: code = 6'h25;
            4'hA: code = 6'h26;
            4'hB: code = 6'h23;
            4'hC: code = 6'h34;
            4'hD: code = 6'h31;
            4'hE: code = 6'h32;
            default: code = 6'h29;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### src/wtfe_step.sv
// Per-item encoding logic: next frame state and up to three result bytes.
`default_nettype none

module wtfe_step import wtfe_pkg::*;
(
    input  cfg_t                     cfg,
    input  enc_state_t               state,
    input  in_item_t                 item,
    output enc_state_t               state_next,
    output out_item_t [RES_MAX-1:0]  res,
    output logic [1:0]               res_cnt
);

    logic [8:0]  pre_len;
    logic [8:0]  hdr_ofs;
    logic [8:0]  hdr_index_sync;
    logic [1:0]  sync_k;
    logic [31:0] sync_sel;
    logic [7:0]  sync_byte;
    logic [11:0] t_word;

    // Header position and sync word selection.
    always_comb
    begin
        pre_len = PREAMBLE_MIN + {1'b0, cfg.preamble_extra};
        hdr_ofs = state.header_index - pre_len;
        sync_k  = (hdr_ofs > 9'd3) ? 2'd3 : hdr_ofs[1:0];
        hdr_index_sync = pre_len + {7'd0, sync_k} + 9'd1;
        case (cfg.coding_mode)
            MODE_S:  sync_sel = SYNC_S;
            MODE_T:  sync_sel = SYNC_T;
            default: sync_sel = cfg.frame_format_b ? SYNC_C_B : SYNC_C_A;
        endcase
        case (sync_k)
            2'd0:    sync_byte = sync_sel[31:24];
            2'd1:    sync_byte = sync_sel[23:16];
            2'd2:    sync_byte = sync_sel[15:8];
            default: sync_byte = sync_sel[7:0];
        endcase
        t_word = {six_code(item.payload_byte[7:4]), six_code(item.payload_byte[3:0])};
    end

    // Item decode, state update and result bytes.
    always_comb
    begin
        state_next = state;
        res        = '0;
        res_cnt    = 2'd0;
        case (item.action)
            ACT_START:
            begin
                state_next.header_index    = 9'd0;
                state_next.header_done     = 1'b0;
                state_next.residual_nibble = 4'd0;
                state_next.residual_valid  = 1'b0;
                state_next.frame_active    = 1'b1;
            end
            ACT_HEADER:
            begin
                if (state.frame_active && !state.header_done)
                begin
                    res_cnt = 2'd1;
                    if (state.header_index < pre_len)
                    begin
                        res[0].out_byte = PREAMBLE_BYTE;
                        state_next.header_index = state.header_index + 9'd1;
                    end
                    else
                    begin
                        res[0].out_byte    = sync_byte;
                        res[0].header_last = (sync_k == 2'd3);
                        state_next.header_index = hdr_index_sync;
                        if (sync_k == 2'd3)
                        begin
                            state_next.header_done = 1'b1;
                        end
                    end
                end
            end
            ACT_PAYLOAD:
            begin
                if (state.frame_active && state.header_done)
                begin
                    case (cfg.coding_mode)
                        MODE_S:
                        begin
                            res[0].out_byte   = manch_byte(item.payload_byte[7:4]);
                            res[1].out_byte   = manch_byte(item.payload_byte[3:0]);
                            res[1].frame_last = item.last_byte;
                            res_cnt = 2'd2;
                        end
                        MODE_T:
                        begin
                            if (state.residual_valid)
                            begin
                                // Pending nibble plus two codewords fill two bytes.
                                res[0].out_byte = {state.residual_nibble, t_word[11:8]};
                                res[1].out_byte = t_word[7:0];
                                res_cnt = 2'd2;
                                state_next.residual_valid  = 1'b0;
                                state_next.residual_nibble = 4'd0;
                                if (item.last_byte)
                                begin
                                    res[2].out_byte   = POSTAMBLE_FULL;
                                    res[2].frame_last = 1'b1;
                                    res_cnt = 2'd3;
                                end
                            end
                            else
                            begin
                                // One byte out, the low nibble stays pending.
                                res[0].out_byte = t_word[11:4];
                                res_cnt = 2'd1;
                                state_next.residual_valid  = 1'b1;
                                state_next.residual_nibble = t_word[3:0];
                                if (item.last_byte)
                                begin
                                    res[1].out_byte   = {t_word[3:0], POSTAMBLE_TAIL};
                                    res[1].frame_last = 1'b1;
                                    res_cnt = 2'd2;
                                    state_next.residual_valid  = 1'b0;
                                    state_next.residual_nibble = 4'd0;
                                end
                            end
                        end
                        default:
                        begin
                            res[0].out_byte   = item.payload_byte;
                            res[0].frame_last = item.last_byte;
                            res_cnt = 2'd1;
                        end
                    endcase
                    if (item.last_byte)
                    begin
                        state_next.frame_active = 1'b0;
                        state_next.header_done  = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/wmbus_tx_frame_encoder.sv
// Top level of the wireless meter bus transmit frame encoder.
//
//  Channel   | Signals                          | Content
//  ----------+----------------------------------+-------------------------------------
//  item      | item_valid, item_ready, item     | action, payload byte, last flag
//  result    | result_valid, result_ready, result | output byte, header and frame flags
//  config    | psel, penable, pwrite, paddr,    | coding mode, frame format,
//            | pwdata, prdata, pready           | extra preamble bytes
//
// Each accepted item is encoded in the cycle of its transfer and its zero to three result
// bytes are loaded into a three-entry result register.
// The result register drains one byte per cycle while result_ready is high, so items
// with one result each sustain one item per cycle; an item with n results holds the
// output until all n have left. A new item is taken while the last waiting byte leaves;
// reset sets frame state, result count and config registers to their reset values.
`default_nettype none

module wmbus_tx_frame_encoder import wtfe_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire in_item_t           item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output out_item_t               result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    cfg_t                     cfg_reg;
    cfg_t                     cfg_next;
    enc_state_t               state_reg;
    enc_state_t               state_step;
    enc_state_t               state_next;
    out_item_t [RES_MAX-1:0]  slot_reg;
    out_item_t [RES_MAX-1:0]  slot_next;
    out_item_t [RES_MAX-1:0]  step_res;
    logic [1:0]               step_cnt;
    logic [1:0]               cnt_reg;
    logic [1:0]               cnt_next;
    logic                     item_xfer;
    logic                     result_xfer;
    logic                     cfg_write;
    reg_index_t               cfg_index;

    // Configuration register writes and reads.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = 32'd0;
        unique case (cfg_index)
            REG_CODING_MODE:
            begin
                prdata = {30'd0, cfg_reg.coding_mode};
                if (cfg_write)
                begin
                    cfg_next.coding_mode = mode_t'(pwdata[1:0]);
                end
            end
            REG_FRAME_FORMAT_B:
            begin
                prdata = {31'd0, cfg_reg.frame_format_b};
                if (cfg_write)
                begin
                    cfg_next.frame_format_b = pwdata[0];
                end
            end
            REG_PREAMBLE_EXTRA:
            begin
                prdata = {24'd0, cfg_reg.preamble_extra};
                if (cfg_write)
                begin
                    cfg_next.preamble_extra = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coding_mode    <= CODING_MODE_RESET;
            cfg_reg.frame_format_b <= 1'b0;
            cfg_reg.preamble_extra <= 8'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Encoding of the item in transfer.
    wtfe_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item),
        .state_next (state_step),
        .res        (step_res),
        .res_cnt    (step_cnt)
    );

    // Handshake: room exists once the result register is empty or about to be.
    assign result_valid = (cnt_reg != 2'd0);
    assign result       = slot_reg[0];
    assign result_xfer  = result_valid && result_ready;
    assign item_ready   = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && result_ready);
    assign item_xfer    = item_valid && item_ready;
    assign state_next   = item_xfer ? state_step : state_reg;

    // Result register: shift out on a transfer, load a new group of bytes.
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (result_xfer)
        begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_next     = cnt_reg - 2'd1;
        end
        if (item_xfer && (step_cnt != 2'd0))
        begin
            slot_next = step_res;
            cnt_next  = step_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

`ifndef SYNTHESIS
    // A header item in an open frame always leaves a byte waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.action == ACT_HEADER) && state_reg.frame_active
            && !state_reg.header_done) |=> result_valid)
    else $error("header item produced no result byte");

    // A sync byte never closes the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.header_last && result.frame_last))
    else $error("result marks both header end and frame end");

    // A start item opens a clean frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_xfer && (item.action == ACT_START)) |=>
            (state_reg.frame_active && !state_reg.header_done
                && !state_reg.residual_valid && (state_reg.header_index == 9'd0)))
    else $error("start item did not reset the frame state");
`endif

endmodule

`default_nettype wire

### dv/wtfe_checker.sv
// Checker for the frame encoder: it predicts the transmitted bytes and compares them.
module wtfe_checker import wtfe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  logic               item_ready,
    input  in_item_t           item,
    input  logic               result_valid,
    input  logic               result_ready,
    input  out_item_t          result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 pending,
    output int                 fail_count
);

    // Code tables, entry for nibble 0 in the lowest bits.
    localparam logic [16*8-1:0] MANCH_TAB = {
        8'h55, 8'h56, 8'h59, 8'h5A, 8'h65, 8'h66, 8'h69, 8'h6A,
        8'h95, 8'h96, 8'h99, 8'h9A, 8'hA5, 8'hA6, 8'hA9, 8'hAA};
    localparam logic [16*6-1:0] SIX_TAB = {
        6'h29, 6'h32, 6'h31, 6'h34, 6'h23, 6'h26, 6'h25, 6'h2C,
        6'h13, 6'h1A, 6'h19, 6'h1C, 6'h0B, 6'h0E, 6'h0D, 6'h16};

    // Register copies as seen on the configuration port.
    mode_t      cfg_mode;
    logic       cfg_fmt_b;
    logic [7:0] cfg_extra;

    // Frame state of the encoder.
    logic [8:0] hdr_idx;
    logic       hdr_done;
    logic [3:0] nib;
    logic       nib_valid;
    logic       frame_open;

    out_item_t  tx_byte_q[$];
    int         mismatch_count = 0;
    int         queued = 0;

    assign pending    = queued;
    assign fail_count = mismatch_count;

    function automatic out_item_t tx_byte(input logic [7:0] b, input logic hl,
                                          input logic fl);
        out_item_t r;
        r.out_byte    = b;
        r.header_last = hl;
        r.frame_last  = fl;
        return r;
    endfunction

    // Work out the bytes that one accepted item sends and queue them.
    task automatic encode_item(input in_item_t it);
        logic [8:0]  pre;
        logic [8:0]  k;
        logic [31:0] sync;
        logic [11:0] w;
        case (it.action)
            ACT_START:
            begin
                hdr_idx    = '0;
                hdr_done   = 1'b0;
                nib        = '0;
                nib_valid  = 1'b0;
                frame_open = 1'b1;
            end
            ACT_HEADER:
            begin
                if (frame_open && !hdr_done)
                begin
                    pre = PREAMBLE_MIN + {1'b0, cfg_extra};
                    if (hdr_idx < pre)
                    begin
                        tx_byte_q.push_back(tx_byte(PREAMBLE_BYTE, 1'b0, 1'b0));
                        hdr_idx = hdr_idx + 9'd1;
                    end
                    else
                    begin
                        // Past the preamble; an index beyond the sync word clamps to its end.
                        k = hdr_idx - pre;
                        if (k > 9'd3)
                            k = 9'd3;
                        if (cfg_mode == MODE_S)
                            sync = SYNC_S;
                        else if (cfg_mode == MODE_T)
                            sync = SYNC_T;
                        else
                            sync = cfg_fmt_b ? SYNC_C_B : SYNC_C_A;
                        tx_byte_q.push_back(tx_byte(sync[8*(3-k) +: 8], k == 9'd3, 1'b0));
                        hdr_idx = pre + k + 9'd1;
                        if (k == 9'd3)
                            hdr_done = 1'b1;
                    end
                end
            end
            ACT_PAYLOAD:
            begin
                if (frame_open && hdr_done)
                begin
                    if (cfg_mode == MODE_S)
                    begin
                        tx_byte_q.push_back(tx_byte(MANCH_TAB[it.payload_byte[7:4]*8 +: 8],
                                                    1'b0, 1'b0));
                        tx_byte_q.push_back(tx_byte(MANCH_TAB[it.payload_byte[3:0]*8 +: 8],
                                                    1'b0, it.last_byte));
                    end
                    else if (cfg_mode == MODE_T)
                    begin
                        w = {SIX_TAB[it.payload_byte[7:4]*6 +: 6],
                             SIX_TAB[it.payload_byte[3:0]*6 +: 6]};
                        if (nib_valid)
                        begin
                            tx_byte_q.push_back(tx_byte({nib, w[11:8]}, 1'b0, 1'b0));
                            tx_byte_q.push_back(tx_byte(w[7:0], 1'b0, 1'b0));
                            nib       = '0;
                            nib_valid = 1'b0;
                        end
                        else
                        begin
                            tx_byte_q.push_back(tx_byte(w[11:4], 1'b0, 1'b0));
                            nib       = w[3:0];
                            nib_valid = 1'b1;
                        end
                        // Postamble carries the leftover nibble, or a full filler byte.
                        if (it.last_byte)
                        begin
                            tx_byte_q.push_back(tx_byte(nib_valid ? {nib, POSTAMBLE_TAIL}
                                                                  : POSTAMBLE_FULL,
                                                        1'b0, 1'b1));
                            nib       = '0;
                            nib_valid = 1'b0;
                        end
                    end
                    else
                    begin
                        tx_byte_q.push_back(tx_byte(it.payload_byte, 1'b0, it.last_byte));
                    end
                    if (it.last_byte)
                    begin
                        frame_open = 1'b0;
                        hdr_done   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Compare one sent byte with the oldest prediction.
    task automatic check_byte(input out_item_t got);
        out_item_t want;
        if (tx_byte_q.size() == 0)
        begin
            if (mismatch_count < 10)
                $display("unexpected byte %02h hl %0b fl %0b", got.out_byte,
                         got.header_last, got.frame_last);
            mismatch_count++;
        end
        else
        begin
            want = tx_byte_q.pop_front();
            if (got.out_byte !== want.out_byte || got.header_last !== want.header_last ||
                got.frame_last !== want.frame_last)
            begin
                if (mismatch_count < 10)
                    $display("mismatch: expected byte %02h hl %0b fl %0b, got byte %02h hl %0b fl %0b",
                             want.out_byte, want.header_last, want.frame_last,
                             got.out_byte, got.header_last, got.frame_last);
                mismatch_count++;
            end
        end
    endtask

    // Watch the three ports at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_mode   = CODING_MODE_RESET;
            cfg_fmt_b  = 1'b0;
            cfg_extra  = '0;
            hdr_idx    = '0;
            hdr_done   = 1'b0;
            nib        = '0;
            nib_valid  = 1'b0;
            frame_open = 1'b0;
            tx_byte_q.delete();
            queued <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
                check_byte(result);
            if (item_valid && item_ready)
                encode_item(item);
            if (psel && penable && pwrite && pready)
            begin
                case (reg_index_t'(paddr[3:2]))
                    REG_CODING_MODE:    cfg_mode  = mode_t'(pwdata[1:0]);
                    REG_FRAME_FORMAT_B: cfg_fmt_b = pwdata[0];
                    REG_PREAMBLE_EXTRA: cfg_extra = pwdata[7:0];
                    default:
                    begin
                    end
                endcase
            end
            queued <= tx_byte_q.size();
        end
    end

endmodule

### dv/wmbus_tx_frame_encoder_test.sv
// Testbench top for the frame encoder: clock, reset, stimulus, receiver stalls and verdict.
module wmbus_tx_frame_encoder_test;
    import wtfe_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 200;
    localparam int ITEM_TARGET  = 420;
    // Items of the closing frame with the largest preamble.
    localparam int BIG_FRAME_ITEMS = 1 + 12 + 255 + 4 + 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_ready;
    in_item_t           item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    out_item_t          result;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    int pending;
    int fail_count;
    int items_sent = 0;
    int burst_left = 0;
    bit no_gaps = 1'b0;
    bit hold_req = 1'b0;

    wmbus_tx_frame_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    wtfe_checker u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .pending      (pending),
        .fail_count   (fail_count)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Random payload byte, with the two extremes more often.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one item, in bursts with random gaps, and wait for its transfer.
    task automatic send_item(input action_t act, input logic [7:0] pb, input logic lst,
                             input bit counted);
        in_item_t it;
        it.action       = act;
        it.payload_byte = pb;
        it.last_byte    = lst;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!no_gaps && $urandom_range(0, 3) != 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        if (counted)
            items_sent++;
    endtask

    // Let every predicted byte drain, then let zero-byte items settle as well.
    task automatic wait_idle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input reg_index_t idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // One frame: mostly well formed, sometimes cut short or with stray items.
    task automatic send_frame(input int extra);
        int n_hdr;
        int n_pay;
        n_hdr = 12 + extra + 4;
        send_item(ACT_START, pick_byte(), 1'($urandom_range(0, 1)), 1);
        if ($urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(0, n_hdr - 1))
                send_item(ACT_HEADER, pick_byte(), 1'($urandom_range(0, 1)), 1);
            send_item(ACT_PAYLOAD, pick_byte(), 1'($urandom_range(0, 1)), 0);
            return;
        end
        for (int i = 0; i < n_hdr; i++)
        begin
            send_item(ACT_HEADER, pick_byte(), 1'($urandom_range(0, 1)), 1);
            if ($urandom_range(0, 19) == 0)
                send_item(ACT_NONE, pick_byte(), 1'($urandom_range(0, 1)), 0);
        end
        if ($urandom_range(0, 7) == 0)
            send_item(ACT_HEADER, pick_byte(), 1'($urandom_range(0, 1)), 0);
        n_pay = $urandom_range(1, 10);
        for (int i = 0; i < n_pay; i++)
            send_item(ACT_PAYLOAD, pick_byte(), i == n_pay - 1, 1);
        if ($urandom_range(0, 7) == 0)
            send_item(ACT_PAYLOAD, pick_byte(), 1'($urandom_range(0, 1)), 0);
    endtask

    // Receiver: random stall segments, and a long hold-off on request.
    initial
    begin
        int seg;
        int pattern;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                pattern = $urandom_range(0, 2);
                seg = $urandom_range(5, 60);
                repeat (seg)
                begin
                    case (pattern)
                        0: result_ready <= 1'b1;
                        1: result_ready <= 1'($urandom_range(0, 1));
                        default: result_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge clk);
                    if (hold_req)
                        break;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("wmbus_tx_frame_encoder test failed");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int extra;
        int phase;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: items out of order with no frame open, all ignored.
        send_item(ACT_NONE, 8'hFF, 1'b1, 0);
        send_item(ACT_HEADER, 8'h00, 1'b0, 0);
        send_item(ACT_PAYLOAD, 8'hFF, 1'b1, 0);

        // Directed: T mode, header begun with a long preamble that is then shortened.
        wait_idle();
        reg_write(REG_CODING_MODE, 32'(MODE_T));
        reg_write(REG_PREAMBLE_EXTRA, 32'd4);
        send_item(ACT_START, 8'h00, 1'b0, 1);
        send_item(ACT_PAYLOAD, 8'hA5, 1'b0, 0);
        repeat (16) send_item(ACT_HEADER, 8'h00, 1'b0, 1);
        wait_idle();
        reg_write(REG_PREAMBLE_EXTRA, 32'd0);
        send_item(ACT_HEADER, 8'h00, 1'b0, 1);
        send_item(ACT_HEADER, 8'hFF, 1'b1, 0);

        // Directed: two payload bytes consume the nibble, so the postamble is a full byte.
        send_item(ACT_PAYLOAD, 8'h00, 1'b0, 1);
        send_item(ACT_PAYLOAD, 8'hFF, 1'b1, 1);

        // Random phases, each with its own register setting.
        phase = 0;
        while (items_sent < ITEM_TARGET - BIG_FRAME_ITEMS)
        begin
            wait_idle();
            extra = (phase == 1) ? 0 : $urandom_range(0, 6);
            reg_write(REG_CODING_MODE, 32'(phase % 4));
            reg_write(REG_FRAME_FORMAT_B, 32'($urandom_range(0, 1)));
            reg_write(REG_PREAMBLE_EXTRA, 32'(extra));
            no_gaps = (phase == 0 || phase == 2 || $urandom_range(0, 3) == 0);
            if (phase == 0 || phase == 2)
                hold_req = 1'b1;
            repeat ($urandom_range(1, 4))
                send_frame(extra);
            phase++;
        end

        // Largest preamble, one frame, in a mode picked at random.
        wait_idle();
        no_gaps = 1'b0;
        reg_write(REG_CODING_MODE, 32'($urandom_range(0, 3)));
        reg_write(REG_FRAME_FORMAT_B, 32'($urandom_range(0, 1)));
        reg_write(REG_PREAMBLE_EXTRA, 32'd255);
        send_frame(255);

        wait_idle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("wmbus_tx_frame_encoder test passed");
        else
            $display("wmbus_tx_frame_encoder test failed");
        $finish;
    end

endmodule
